// ===== rtl/lbt_pkg.sv =====
package lbt_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_THUMB      = 256;

  localparam int DIM_W   = 9;
  localparam int COORD_W = 8;
  localparam int SMP_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int FRAC_W  = 16;
  localparam int PIX_W   = 3 * BYTE_W;
  localparam int BANK_AW = 2 * (COORD_W - 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_MODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_Q_W   = 24;
  localparam int DIV_CMP_W = DIV_DEN_W + DIV_Q_W;

  typedef struct packed {
    logic               empty;
    logic [DIM_W-1:0]   tsz;
    logic [COORD_W-1:0] wm1;
    logic [COORD_W-1:0] hm1;
    logic [DIM_W-1:0]   fw;
    logic [DIM_W-1:0]   fh;
    logic [DIM_W-1:0]   offx;
    logic [DIM_W-1:0]   offy;
    logic               nzx;
    logic               nzy;
    logic [COORD_W-1:0] denx;
    logic [COORD_W-1:0] deny;
    logic               hdr;
    logic               has_g;
    logic               has_b;
  } fit_t;

  typedef struct packed {
    logic               valid;
    logic               fetch;
    logic               in_area;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [BYTE_W-1:0]  r8;
    logic [BYTE_W-1:0]  g8;
    logic [BYTE_W-1:0]  b8;
  } meta_t;

endpackage

// ===== rtl/letterbox_bilinear_thumbnail_core.sv =====
// letterbox bilinear thumbnail core
// input stream (s_axis): tuser is the item mode, 0 loads one source pixel into
// the on-chip store at (pos_x, pos_y), 1 fetches one pixel of the square canvas.
// load items give no output; each fetch gives one output item on m_axis with
// red, green, blue and alpha bytes (all zero in the letterbox or off canvas).
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); after each
// write and after reset a sequential fit unit works out the fitted size and
// the offsets, and s_axis_tready stays low until it finishes.
// throughput is one item per cycle unless stalled; the pipeline is set by
// the 24-stage restoring dividers (one for the coordinate of each axis, one per
// color lane for tone mapping), then the banked store read and two multiply
// stages, and a fetch result then goes to the output register.
// the store is four banks split by row and column parity, so the four
// neighbors of a bilinear tap are read in the same cycle.
// when the receiver stalls the output register holds its item and the
// pipeline keeps taking items until the next result would overwrite it.
// reset (rst, synchronous) clears the pipeline and sets the registers to their
// defaults; the store contents are not cleared.
module letterbox_bilinear_thumbnail_core import lbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [111:0]          s_axis_tdata,  // pos_x, pos_y, red_in, green_in, blue_in
  input  logic                  s_axis_tuser,  // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata   // red_out, green_out, blue_out, alpha_out
);

  localparam int DIV_LAT = DIV_Q_W;
  localparam int M_LAST  = DIV_LAT + 1;

  fit_t fit;
  logic fit_busy;
  logic en, accept;

  logic                    s1_valid, s1_fetch;
  logic [COORD_W-1:0]      s1_px, s1_py;
  logic [2:0][SMP_W-1:0]   s1_smp;

  logic [DIM_W-1:0]        lx, ly;
  logic                    in_area;
  logic [2*COORD_W-1:0]    prodx, prody;
  logic [DIV_NUM_W-1:0]    numx, numy;
  logic [DIV_DEN_W-1:0]    denx, deny;
  logic [DIV_Q_W-1:0]      xq, yq;

  meta_t                   meta_q [2:M_LAST];
  meta_t                   m25;

  logic [2:0][BYTE_W-1:0]  tone;
  logic [COORD_W-1:0]      x0, x1, y0, y1, col, row;
  logic                    xs, ys;
  logic                    we;
  logic [PIX_W-1:0]        wdata;
  logic [3:0][BANK_AW-1:0] raddr;
  logic [3:0][PIX_W-1:0]   rdata;

  logic                    s26_valid, s26_fetch, s26_in_area;
  logic                    s26_x0p, s26_xs, s26_y0p, s26_ys;
  logic [FRAC_W-1:0]       s26_tx, s26_ty;
  logic [PIX_W-1:0]        pa, pb, pd, pe;
  logic [2:0][BYTE_W-1:0]  pix;

  logic                    s27_valid, s27_fetch, s27_in_area;
  logic                    out_valid;
  logic [31:0]             out_data;

  lbt_fit u_fit (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fit       (fit),
    .busy      (fit_busy)
  );

  // stall only when a result would land on an output item not yet taken
  assign en            = !(out_valid && !m_axis_tready && s27_valid && s27_fetch);
  assign s_axis_tready = en && !fit_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fetch  <= s_axis_tuser;
      s1_px     <= s_axis_tdata[7:0];
      s1_py     <= s_axis_tdata[15:8];
      s1_smp[0] <= s_axis_tdata[47:16];
      s1_smp[1] <= s_axis_tdata[79:48];
      s1_smp[2] <= s_axis_tdata[111:80];
    end
  end

  // canvas geometry
  always_comb begin
    lx      = {1'b0, s1_px} - fit.offx;
    ly      = {1'b0, s1_py} - fit.offy;
    in_area = !fit.empty
              && ({1'b0, s1_px} < fit.tsz) && ({1'b0, s1_py} < fit.tsz)
              && ({1'b0, s1_px} >= fit.offx) && ({1'b0, s1_py} >= fit.offy)
              && (lx < fit.fw) && (ly < fit.fh);
    prodx   = (2*COORD_W)'(lx[COORD_W-1:0]) * (2*COORD_W)'(fit.wm1);
    prody   = (2*COORD_W)'(ly[COORD_W-1:0]) * (2*COORD_W)'(fit.hm1);
    numx    = fit.nzx ? (DIV_NUM_W'(prodx) << FRAC_W) : '0;
    numy    = fit.nzy ? (DIV_NUM_W'(prody) << FRAC_W) : '0;
    denx    = DIV_DEN_W'(fit.denx);
    deny    = DIV_DEN_W'(fit.deny);
  end

  lbt_div u_divx (.clk(clk), .en(en), .num(numx), .den(denx), .quo(xq));
  lbt_div u_divy (.clk(clk), .en(en), .num(numy), .den(deny), .quo(yq));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 2; i <= M_LAST; i++) begin
        meta_q[i] <= '0;
      end
    end else if (en) begin
      meta_q[2].valid   <= s1_valid;
      meta_q[2].fetch   <= s1_fetch;
      meta_q[2].in_area <= in_area;
      meta_q[2].px      <= s1_px;
      meta_q[2].py      <= s1_py;
      meta_q[2].r8      <= s1_smp[0][BYTE_W-1:0];
      meta_q[2].g8      <= s1_smp[1][BYTE_W-1:0];
      meta_q[2].b8      <= s1_smp[2][BYTE_W-1:0];
      for (int i = 3; i <= M_LAST; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  assign m25 = meta_q[M_LAST];

  // tap positions and bank addresses
  always_comb begin
    x0 = (xq[DIV_Q_W-1:FRAC_W] > fit.wm1) ? fit.wm1 : xq[DIV_Q_W-1:FRAC_W];
    y0 = (yq[DIV_Q_W-1:FRAC_W] > fit.hm1) ? fit.hm1 : yq[DIV_Q_W-1:FRAC_W];
    xs = !(x0 < fit.wm1);
    ys = !(y0 < fit.hm1);
    x1 = xs ? x0 : x0 + COORD_W'(1);
    y1 = ys ? y0 : y0 + COORD_W'(1);
    for (int k = 0; k < 4; k++) begin
      col      = (x0[0] == k[0]) ? x0 : x1;
      row      = (y0[0] == k[1]) ? y0 : y1;
      raddr[k] = {row[COORD_W-1:1], col[COORD_W-1:1]};
    end
    we       = en && m25.valid && !m25.fetch;
    wdata[7:0]   = fit.hdr ? tone[0] : m25.r8;
    wdata[15:8]  = fit.hdr ? (fit.has_g ? tone[1] : tone[0]) : m25.g8;
    wdata[23:16] = fit.hdr ? (fit.has_b ? tone[2] : tone[0]) : m25.b8;
  end

  lbt_store u_store (
    .clk   (clk),
    .en    (en),
    .we    (we),
    .wbank ({m25.py[0], m25.px[0]}),
    .waddr ({m25.py[COORD_W-1:1], m25.px[COORD_W-1:1]}),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s26_valid <= 1'b0;
      s27_valid <= 1'b0;
    end else if (en) begin
      s26_valid <= m25.valid;
      s27_valid <= s26_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s26_fetch   <= m25.fetch;
      s26_in_area <= m25.in_area;
      s26_x0p     <= x0[0];
      s26_xs      <= xs;
      s26_y0p     <= y0[0];
      s26_ys      <= ys;
      s26_tx      <= xq[FRAC_W-1:0];
      s26_ty      <= yq[FRAC_W-1:0];
      s27_fetch   <= s26_fetch;
      s27_in_area <= s26_in_area;
    end
  end

  // pick the four neighbors from the parity banks
  always_comb begin
    pa = rdata[{s26_y0p, s26_x0p}];
    pb = s26_xs ? pa : rdata[{s26_y0p, !s26_x0p}];
    pd = s26_ys ? pa : rdata[{!s26_y0p, s26_x0p}];
    if (s26_ys) begin
      pe = pb;
    end else if (s26_xs) begin
      pe = pd;
    end else begin
      pe = rdata[{!s26_y0p, !s26_x0p}];
    end
  end

  genvar c;
  for (c = 0; c < 3; c++) begin : g_lane
    lbt_lane u_lane (
      .clk    (clk),
      .en     (en),
      .sample (s1_smp[c]),
      .tone   (tone[c]),
      .a      (pa[c*BYTE_W +: BYTE_W]),
      .b      (pb[c*BYTE_W +: BYTE_W]),
      .d      (pd[c*BYTE_W +: BYTE_W]),
      .e      (pe[c*BYTE_W +: BYTE_W]),
      .tx     (s26_tx),
      .ty     (s26_ty),
      .pix    (pix[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && s27_valid && s27_fetch) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s27_valid && s27_fetch) begin
      out_data <= s27_in_area ? {8'hFF, pix[2], pix[1], pix[0]} : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    fit_busy |-> !s_axis_tready)
    else $error("item accepted while fit unit busy");

  a_alpha_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'h00 || m_axis_tdata[31:24] == 8'hFF))
    else $error("alpha neither 0 nor 255");

  a_letterbox_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[31:24] == 8'h00) |-> m_axis_tdata[23:0] == '0)
    else $error("letterbox pixel not black");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s27_valid) && $stable(s26_valid))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== rtl/lbt_div.sv =====
module lbt_div import lbt_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   quo
);

  logic [DIV_NUM_W-1:0] rem_q [0:DIV_Q_W-2];
  logic [DIV_DEN_W-1:0] den_q [0:DIV_Q_W-2];
  logic [DIV_Q_W-1:0]   q_q   [0:DIV_Q_W-1];

  genvar i;
  for (i = 0; i < DIV_Q_W; i++) begin : g_stage
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_Q_W-1:0]   q_in;
    logic [DIV_CMP_W-1:0] dsh;
    logic                 ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign q_in   = q_q[i-1];
    end

    // one quotient bit per stage, msb first
    assign dsh = DIV_CMP_W'(den_in) << (DIV_Q_W - 1 - i);
    assign ge  = DIV_CMP_W'(rem_in) >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[i] <= ge ? (q_in | (DIV_Q_W'(1) << (DIV_Q_W - 1 - i))) : q_in;
      end
    end

    if (i < DIV_Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= ge ? (rem_in - dsh[DIV_NUM_W-1:0]) : rem_in;
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo = q_q[DIV_Q_W-1];

endmodule

// ===== rtl/lbt_fit.sv =====
module lbt_fit import lbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output fit_t                  fit,
  output logic                  busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int NUM_W = 2 * DIM_W;
  localparam int CNT_W = 4;

  logic [DIM_W-1:0] src_width, src_height, canvas_size;
  logic             hdr_mode;
  logic [2:0]       channel_count;
  logic [1:0]       state;

  logic [DIM_W-1:0] ws, hs, ts, big, short_dim, fs, fb, fw_n, fh_n;
  logic             wide_n;
  logic [NUM_W-1:0] num_n;

  logic             wide;
  logic [NUM_W-1:0] rem;
  logic [DIM_W:0]   dv;
  logic [DIM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W:0]   dsh;
  logic             ge;

  logic               empty;
  logic [DIM_W-1:0]   fw, fh, offx, offy;
  logic [COORD_W-1:0] denx, deny;
  logic               nzx, nzy;

  always_comb begin
    ws     = (src_width  > DIM_W'(MAX_SRC_WIDTH))  ? DIM_W'(MAX_SRC_WIDTH)  : src_width;
    hs     = (src_height > DIM_W'(MAX_SRC_HEIGHT)) ? DIM_W'(MAX_SRC_HEIGHT) : src_height;
    ts     = (canvas_size > DIM_W'(MAX_THUMB))     ? DIM_W'(MAX_THUMB)      : canvas_size;
    wide_n = ws >= hs;
    big    = wide_n ? ws : hs;
    short_dim = wide_n ? hs : ws;
    num_n  = ((NUM_W'(short_dim) * NUM_W'(ts)) << 1) + NUM_W'(big);
    dsh    = (NUM_W+1)'(dv) << cnt;
    ge     = {1'b0, rem} >= dsh;
    fs     = (quo == '0) ? DIM_W'(1) : quo;
    fb     = (ts == '0) ? DIM_W'(1) : ts;
    fw_n   = wide ? fb : fs;
    fh_n   = wide ? fs : fb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= '0;
      src_height    <= '0;
      canvas_size   <= DIM_W'(64);
      hdr_mode      <= 1'b0;
      channel_count <= 3'd4;
      state         <= ST_SETUP;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:     src_width     <= cfg_data;
          REG_SRC_HEIGHT:    src_height    <= cfg_data;
          REG_CANVAS_SIZE:   canvas_size   <= cfg_data;
          REG_HDR_MODE:      hdr_mode      <= cfg_data[0];
          REG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cfg_we) begin
        state <= ST_SETUP;
      end else begin
        case (state)
          ST_IDLE:  state <= ST_IDLE;
          ST_SETUP: state <= ST_DIV;
          ST_DIV:   state <= (cnt == '0) ? ST_DONE : ST_DIV;
          ST_DONE:  state <= ST_IDLE;
          default:  state <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SETUP: begin
        wide  <= wide_n;
        rem   <= num_n;
        dv    <= {big, 1'b0};
        quo   <= '0;
        cnt   <= CNT_W'(DIM_W - 1);
        empty <= (ws == '0) || (hs == '0);
      end
      ST_DIV: begin
        if (ge) begin
          rem <= rem - dsh[NUM_W-1:0];
          quo <= quo | (DIM_W'(1) << cnt);
        end
        cnt <= cnt - CNT_W'(1);
      end
      ST_DONE: begin
        fw   <= fw_n;
        fh   <= fh_n;
        offx <= (ts - fw_n) >> 1;
        offy <= (ts - fh_n) >> 1;
        nzx  <= fw_n > DIM_W'(1);
        nzy  <= fh_n > DIM_W'(1);
        denx <= (fw_n > DIM_W'(1)) ? COORD_W'(fw_n - DIM_W'(1)) : COORD_W'(1);
        deny <= (fh_n > DIM_W'(1)) ? COORD_W'(fh_n - DIM_W'(1)) : COORD_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    fit.empty = empty;
    fit.tsz   = ts;
    fit.wm1   = COORD_W'(ws - DIM_W'(1));
    fit.hm1   = COORD_W'(hs - DIM_W'(1));
    fit.fw    = fw;
    fit.fh    = fh;
    fit.offx  = offx;
    fit.offy  = offy;
    fit.nzx   = nzx;
    fit.nzy   = nzy;
    fit.denx  = denx;
    fit.deny  = deny;
    fit.hdr   = hdr_mode;
    fit.has_g = channel_count > 3'd1;
    fit.has_b = channel_count > 3'd2;
  end

  assign busy = state != ST_IDLE;

endmodule

// ===== rtl/lbt_lane.sv =====
module lbt_lane import lbt_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SMP_W-1:0]  sample,
  output logic [BYTE_W-1:0] tone,
  input  logic [BYTE_W-1:0] a,
  input  logic [BYTE_W-1:0] b,
  input  logic [BYTE_W-1:0] d,
  input  logic [BYTE_W-1:0] e,
  input  logic [FRAC_W-1:0] tx,
  input  logic [FRAC_W-1:0] ty,
  output logic [BYTE_W-1:0] pix
);

  localparam int WT_W  = FRAC_W + 1;
  localparam int ROW_W = BYTE_W + WT_W;
  localparam int ACC_W = ROW_W + WT_W;

  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_Q_W-1:0]   quo;

  logic [WT_W-1:0]  ux, fx, uy, fy;
  logic [ROW_W-1:0] r0, r1, r0_q, r1_q;
  logic [FRAC_W-1:0] ty_q;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-2*FRAC_W-1:0] top_bits;

  // reinhard tone map: 255*v / (v + 1.0), negative gives zero
  always_comb begin
    if (sample[SMP_W-1]) begin
      num = '0;
      den = DIV_DEN_W'(1);
    end else begin
      num = DIV_NUM_W'(sample[SMP_W-2:0]) * DIV_NUM_W'(255);
      den = DIV_DEN_W'(sample[SMP_W-2:0]) + DIV_DEN_W'(65536);
    end
  end

  lbt_div u_div (
    .clk (clk),
    .en  (en),
    .num (num),
    .den (den),
    .quo (quo)
  );

  assign tone = quo[BYTE_W-1:0];

  always_comb begin
    fx = WT_W'(tx);
    ux = (WT_W'(1) << FRAC_W) - fx;
    r0 = ROW_W'(a) * ROW_W'(ux) + ROW_W'(b) * ROW_W'(fx);
    r1 = ROW_W'(d) * ROW_W'(ux) + ROW_W'(e) * ROW_W'(fx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_q <= r0;
      r1_q <= r1;
      ty_q <= ty;
    end
  end

  always_comb begin
    fy       = WT_W'(ty_q);
    uy       = (WT_W'(1) << FRAC_W) - fy;
    acc      = ACC_W'(r0_q) * ACC_W'(uy) + ACC_W'(r1_q) * ACC_W'(fy);
    top_bits = acc[ACC_W-1:2*FRAC_W];
    pix      = (top_bits > (ACC_W-2*FRAC_W)'(255)) ? BYTE_W'(255) : top_bits[BYTE_W-1:0];
  end

endmodule

// ===== rtl/lbt_store.sv =====
module lbt_store import lbt_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    we,
  input  logic [1:0]              wbank,
  input  logic [BANK_AW-1:0]      waddr,
  input  logic [PIX_W-1:0]        wdata,
  input  logic [3:0][BANK_AW-1:0] raddr,
  output logic [3:0][PIX_W-1:0]   rdata
);

  genvar k;
  for (k = 0; k < 4; k++) begin : g_bank
    logic [PIX_W-1:0] mem [0:(1<<BANK_AW)-1];

    always_ff @(posedge clk) begin
      if (en) begin
        if (we && (wbank == 2'(k))) begin
          mem[waddr] <= wdata;
        end
        rdata[k] <= mem[raddr[k]];
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lbt_pkg::*;

  class thumb_scoreboard;
    bit [23:0] img [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
    int unsigned src_w = 0, src_h = 0, tsz = 64, hdr = 0, chans = 4;
    logic [31:0] pixel_q[$];
    int errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      case (idx)
        REG_SRC_WIDTH:     src_w = val & 9'h1ff;
        REG_SRC_HEIGHT:    src_h = val & 9'h1ff;
        REG_CANVAS_SIZE:   tsz = val & 9'h1ff;
        REG_HDR_MODE:      hdr = val & 1;
        REG_CHANNEL_COUNT: chans = val & 7;
        default: ;
      endcase
    endfunction

    function void add_result(logic [31:0] val);
      pixel_q.insert(pixel_q.size(), val);
    endfunction

    function bit [7:0] tone(logic [31:0] v);
      longint unsigned u;
      u = v;
      if (v[31]) return 0;
      return 8'((255 * u) / (u + 65536));
    endfunction

    function void place(int unsigned x, int unsigned fit, int unsigned size,
                        output int unsigned i0, output int unsigned i1,
                        output longint unsigned frac);
      longint unsigned pos;
      pos = 0;
      if (fit > 1) pos = ((longint'(x) * (size - 1)) << 16) / (fit - 1);
      i0 = 32'(pos >> 16);
      if (i0 > size - 1) i0 = size - 1;
      i1 = (i0 + 1 < size) ? i0 + 1 : size - 1;
      frac = pos & 16'hffff;
    endfunction

    function void note_item(bit mode, bit [7:0] px, bit [7:0] py,
                            logic [31:0] r, logic [31:0] g, logic [31:0] b);
      bit [7:0] rr, gg, bb, outc [3];
      int unsigned w, h, t, fw, fh, lx, ly, x0, x1, y0, y1;
      longint unsigned tx, ty, a, bq, d, e, r0, r1, v;
      if (mode == 0) begin
        if (hdr != 0) begin
          rr = tone(r);
          gg = chans > 1 ? tone(g) : rr;
          bb = chans > 2 ? tone(b) : rr;
        end else begin
          rr = r[7:0]; gg = g[7:0]; bb = b[7:0];
        end
        img[py * MAX_SRC_WIDTH + px] = {bb, gg, rr};
        return;
      end
      w = src_w > MAX_SRC_WIDTH ? MAX_SRC_WIDTH : src_w;
      h = src_h > MAX_SRC_HEIGHT ? MAX_SRC_HEIGHT : src_h;
      t = tsz > MAX_THUMB ? MAX_THUMB : tsz;
      if (w == 0 || h == 0 || px >= t || py >= t) begin
        add_result(32'h0);
        return;
      end
      if (w >= h) begin
        fw = t; fh = (2 * h * t + w) / (2 * w);
      end else begin
        fh = t; fw = (2 * w * t + h) / (2 * h);
      end
      if (fw < 1) fw = 1;
      if (fh < 1) fh = 1;
      if (px < (t - fw) / 2 || py < (t - fh) / 2) begin
        add_result(32'h0);
        return;
      end
      lx = px - (t - fw) / 2;
      ly = py - (t - fh) / 2;
      if (lx >= fw || ly >= fh) begin
        add_result(32'h0);
        return;
      end
      place(lx, fw, w, x0, x1, tx);
      place(ly, fh, h, y0, y1, ty);
      for (int c = 0; c < 3; c++) begin
        a  = img[y0 * MAX_SRC_WIDTH + x0][8*c +: 8];
        bq = img[y0 * MAX_SRC_WIDTH + x1][8*c +: 8];
        d  = img[y1 * MAX_SRC_WIDTH + x0][8*c +: 8];
        e  = img[y1 * MAX_SRC_WIDTH + x1][8*c +: 8];
        r0 = a * (65536 - tx) + bq * tx;
        r1 = d * (65536 - tx) + e * tx;
        v = (r0 * (65536 - ty) + r1 * ty) >> 32;
        outc[c] = v > 255 ? 8'd255 : v[7:0];
      end
      add_result({8'd255, outc[2], outc[1], outc[0]});
    endfunction

    function void check(logic [31:0] act);
      logic [31:0] exp_px;
      if (pixel_q.size() == 0) begin
        $error("unexpected output item %h", act);
        errors++;
        return;
      end
      exp_px = pixel_q.pop_front();
      if (act[7:0] !== exp_px[7:0]) begin
        $error("red_out exp %0d got %0d", exp_px[7:0], act[7:0]); errors++;
      end
      if (act[15:8] !== exp_px[15:8]) begin
        $error("green_out exp %0d got %0d", exp_px[15:8], act[15:8]); errors++;
      end
      if (act[23:16] !== exp_px[23:16]) begin
        $error("blue_out exp %0d got %0d", exp_px[23:16], act[23:16]); errors++;
      end
      if (act[31:24] !== exp_px[31:24]) begin
        $error("alpha_out exp %0d got %0d", exp_px[31:24], act[31:24]); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;

  thumb_scoreboard sb = new();
  int idle_mode = 0;
  int quiet_cycles = 0;

  letterbox_bilinear_thumbnail_core u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int idle_pct(bit sender);
    case (idle_mode)
      1: return sender ? 76 : 0;
      2: return sender ? 0 : 76;
      3: return 13;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= idle_pct(0));
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(255);
      2: return 32'h8000_0000 | $urandom;
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  task automatic send_item(bit mode, bit [7:0] px, bit [7:0] py);
    logic [31:0] r, g, b;
    r = pick_sample(); g = pick_sample(); b = pick_sample();
    if ($urandom_range(99) < idle_pct(1)) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct(1)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {b, g, r, py, px};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(mode, px, py, r, g, b);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  initial begin
    int unsigned w, h, t, ew, eh;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty source straight after reset
    send_item(1, 0, 0);
    send_item(1, 255, 255);
    send_item(1, 10, 20);
    send_item(0, 255, 255);
    send_item(0, 0, 0);
    send_item(1, 0, 0);

    for (int ph = 0; ph < 16; ph++) begin
      drain();
      idle_mode = ph % 4;
      case (ph)
        0: begin w = 300; h = 1; t = 511; end
        1: begin w = 1; h = 256; t = 256; end
        2: begin w = 0; h = 5; t = 1; end
        3: begin w = 4; h = 0; t = 8; end
        4: begin w = 1; h = 1; t = 1; end
        5: begin w = 16; h = 3; t = 200; end
        default: begin
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 6);
          t = $urandom_range(1, 40);
        end
      endcase
      write_reg(REG_SRC_WIDTH, w);
      write_reg(REG_SRC_HEIGHT, h);
      write_reg(REG_CANVAS_SIZE, t);
      write_reg(REG_HDR_MODE, ph % 3 != 0);
      write_reg(REG_CHANNEL_COUNT, ph == 7 ? 7 : $urandom_range(1, 4));
      cfg_we <= 0;
      ew = w > MAX_SRC_WIDTH ? MAX_SRC_WIDTH : w;
      eh = h > MAX_SRC_HEIGHT ? MAX_SRC_HEIGHT : h;
      if (t > MAX_THUMB) t = MAX_THUMB;
      for (int y = 0; y < eh; y++)
        for (int x = 0; x < ew; x++)
          send_item(0, 8'(x), 8'(y));
      for (int n = 0; n < 15; n++) begin
        if (ph == 5 && n == 8) drain();
        if ($urandom_range(9) < 2)
          send_item(0, 8'($urandom), 8'($urandom));
        else if ($urandom_range(9) == 0)
          send_item(1, 8'($urandom), 8'($urandom));
        else
          send_item(1, 8'($urandom_range(t + 1 > 255 ? 255 : t + 1)),
                    8'($urandom_range(t + 1 > 255 ? 255 : t + 1)));
      end
    end

    drain();
    if (sb.errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
